FILE: hw/rtl/vpts_pkg.sv
package vpts_pkg;

  localparam int COORD_W   = 32;
  localparam int MAT_W     = 64;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);
  localparam int PROD_W    = 2 * COORD_W;
  localparam int TERM_W    = PROD_W - 8;
  localparam int CLIP_W    = 58;
  localparam int FRAC_W    = 16;
  localparam int NUM_W     = CLIP_W + FRAC_W;
  localparam int QUO_W     = 40;
  localparam int QIDX_W    = 6;
  localparam int DIV_STEPS = QUO_W + 1;
  localparam int NDC_W     = QUO_W + 2;
  localparam int SIZE_W    = 17;
  localparam int SCALED_W  = NDC_W + SIZE_W;
  localparam int Q_DEPTH   = 4;
  localparam int PTR_W     = $clog2(Q_DEPTH);

  localparam logic signed [NDC_W-1:0] ONE_Q16   = NDC_W'(65536);
  localparam logic signed [NDC_W-1:0] NDC_CLAMP = NDC_W'(1) <<< QUO_W;

  localparam logic [MAT_W-1:0] MAT_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [CLIP_W-1:0] clip_val_t;

  typedef struct packed {
    clip_val_t cx;
    clip_val_t cy;
    clip_val_t cz;
    clip_val_t cw;
  } clip_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [CLIP_W-1:0] den;
    logic [QUO_W-1:0]  quo;
    logic              neg;
    logic              clamp;
  } div_t;

endpackage

FILE: hw/rtl/vpts_if.sv
interface vpts_in_if;
  logic                  valid;
  logic                  ready;
  logic signed [31:0]    point_x;
  logic signed [31:0]    point_y;
  logic signed [31:0]    point_z;

  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface vpts_out_if;
  logic                  valid;
  logic                  ready;
  logic signed [31:0]    screen_x;
  logic signed [31:0]    screen_y;
  logic signed [31:0]    depth;
  logic                  w_zero;
  logic                  overflow;

  modport source (output valid, output screen_x, output screen_y, output depth,
                  output w_zero, output overflow, input ready);
  modport sink (input valid, input screen_x, input screen_y, input depth,
                input w_zero, input overflow, output ready);
endinterface

FILE: hw/rtl/vpts_front.sv
module vpts_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vpts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vpts_pkg::MAT_W-1:0]      cfg_data,
  vpts_in_if.sink                         points,
  input  vpts_pkg::q_status_t             q_st,
  output logic                            push_valid,
  output vpts_pkg::clip_t                 push_data
);
  import vpts_pkg::*;

  logic [MAT_W-1:0] mat [NUM_REGS];
  coord_t m [4][4];
  coord_t pt [3];

  logic                     s1_valid;
  logic signed [PROD_W-1:0] prod [4][3];
  coord_t                   last [4];
  logic                     s2_valid;
  clip_val_t                row_sum [4];
  clip_val_t                row_next [4];
  logic                     en;

  // Product divided by 256 with truncation toward zero.
  function automatic logic signed [TERM_W-1:0] trunc256(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + {{(PROD_W-8){1'b0}}, {8{p[PROD_W-1]}}};
    return t[PROD_W-1:8];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= MAT_RESET;
    end else if (cfg_we) begin
      mat[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = mat[CFG_IDX_W'(r * 2 + c / 2)][(c % 2) * COORD_W +: COORD_W];
      end
    end
    pt[0] = points.point_x;
    pt[1] = points.point_y;
    pt[2] = points.point_z;
  end

  assign en = !(s2_valid && q_st.full);
  assign points.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= points.valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= m[r][c] * pt[c];
        end
        last[r] <= m[r][3];
      end
      row_sum <= row_next;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      row_next[r] = CLIP_W'(trunc256(prod[r][0])) + CLIP_W'(trunc256(prod[r][1]))
                  + CLIP_W'(trunc256(prod[r][2]))
                  + {{(CLIP_W-COORD_W-8){last[r][COORD_W-1]}}, last[r], 8'd0};
    end
  end

  assign push_valid   = s2_valid && !q_st.full;
  assign push_data.cx = row_sum[0];
  assign push_data.cy = row_sum[1];
  assign push_data.cz = row_sum[2];
  assign push_data.cw = row_sum[3];

endmodule

FILE: hw/rtl/vpts_queue.sv
module vpts_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  vpts_pkg::clip_t     push_data,
  input  logic                pop,
  output vpts_pkg::clip_t     pop_data,
  output vpts_pkg::q_status_t q_st
);
  import vpts_pkg::*;

  clip_t            mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  assign pop_data   = mem[rd_ptr];
  assign q_st.full  = (count == (PTR_W+1)'(Q_DEPTH));
  assign q_st.empty = (count == '0);

endmodule

FILE: hw/rtl/vpts_div.sv
module vpts_div (
  input  logic           clk,
  input  logic           en,
  input  vpts_pkg::div_t din,
  output vpts_pkg::div_t dout
);
  import vpts_pkg::*;

  div_t st [DIV_STEPS+1];

  // One restoring step for quotient bit k; the top step only detects clamping.
  function automatic div_t step(input div_t s, input logic [QIDX_W-1:0] k);
    div_t             r;
    logic [NUM_W-1:0] dsh;
    r   = s;
    dsh = {{FRAC_W{1'b0}}, s.den};
    if ((s.rem >> k) >= dsh) begin
      r.rem = s.rem - (dsh << k);
      if (k == QIDX_W'(QUO_W)) r.clamp = 1'b1;
      else r.quo[k] = 1'b1;
    end
    return r;
  endfunction

  assign st[0] = din;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) st[i+1] <= step(st[i], QIDX_W'(QUO_W - i));
    end
  end

  assign dout = st[DIV_STEPS];

endmodule

FILE: hw/rtl/vpts_back.sv
module vpts_back #(
  parameter int VIEW_WIDTH  = 1920,
  parameter int VIEW_HEIGHT = 1080
) (
  input  logic                clk,
  input  logic                rst,
  input  vpts_pkg::q_status_t q_st,
  output logic                pop,
  input  vpts_pkg::clip_t     pop_data,
  vpts_out_if.source          screen
);
  import vpts_pkg::*;

  localparam logic signed [SIZE_W-1:0] SIZE_X = SIZE_W'(VIEW_WIDTH);
  localparam logic signed [SIZE_W-1:0] SIZE_Y = SIZE_W'(VIEW_HEIGHT);

  logic                  en;
  logic [DIV_STEPS:0]    vld;
  logic [DIV_STEPS:0]    wz;
  div_t                  din [3];
  div_t                  dout [3];
  logic signed [NDC_W-1:0] ndc [3];
  logic                  v1_valid;
  logic                  v1_wz;
  logic signed [SCALED_W-1:0] v1_sx;
  logic signed [SCALED_W-1:0] v1_sy;
  logic signed [NDC_W-1:0]    v1_sz;
  logic [COORD_W:0]      sat_x;
  logic [COORD_W:0]      sat_y;
  logic [COORD_W:0]      sat_z;

  function automatic logic [CLIP_W-1:0] mag(input clip_val_t v);
    return v[CLIP_W-1] ? CLIP_W'(-v) : CLIP_W'(v);
  endfunction

  // Halve toward zero, then clamp to 32 bits; the top bit is the saturation flag.
  function automatic logic [COORD_W:0] half_sat(input logic signed [SCALED_W-1:0] v);
    logic signed [SCALED_W-1:0] t;
    logic signed [SCALED_W-1:0] h;
    t = v + {{(SCALED_W-1){1'b0}}, v[SCALED_W-1]};
    h = t >>> 1;
    if (h > SCALED_W'(32'sh7fff_ffff))       return {1'b1, 32'h7fff_ffff};
    else if (h < -SCALED_W'(33'sh8000_0000)) return {1'b1, 32'h8000_0000};
    else return {1'b0, h[COORD_W-1:0]};
  endfunction

  assign en  = !screen.valid || screen.ready;
  assign pop = en && !q_st.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      v1_valid     <= 1'b0;
      screen.valid <= 1'b0;
    end else if (en) begin
      vld          <= {vld[DIV_STEPS-1:0], pop};
      v1_valid     <= vld[DIV_STEPS];
      screen.valid <= v1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wz <= {wz[DIV_STEPS-1:0], (pop_data.cw == '0)};
      din[0] <= '{rem: {mag(pop_data.cx), {FRAC_W{1'b0}}}, den: mag(pop_data.cw), quo: '0,
                  neg: pop_data.cx[CLIP_W-1] ^ pop_data.cw[CLIP_W-1], clamp: 1'b0};
      din[1] <= '{rem: {mag(pop_data.cy), {FRAC_W{1'b0}}}, den: mag(pop_data.cw), quo: '0,
                  neg: pop_data.cy[CLIP_W-1] ^ pop_data.cw[CLIP_W-1], clamp: 1'b0};
      din[2] <= '{rem: {mag(pop_data.cz), {FRAC_W{1'b0}}}, den: mag(pop_data.cw), quo: '0,
                  neg: pop_data.cz[CLIP_W-1] ^ pop_data.cw[CLIP_W-1], clamp: 1'b0};
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_div
    vpts_div u_div (.clk(clk), .en(en), .din(din[j]), .dout(dout[j]));

    always_comb begin
      if (dout[j].clamp) ndc[j] = dout[j].neg ? -NDC_CLAMP : NDC_CLAMP;
      else if (dout[j].neg) ndc[j] = -$signed({2'b00, dout[j].quo});
      else ndc[j] = $signed({2'b00, dout[j].quo});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_wz <= wz[DIV_STEPS];
      v1_sx <= (ndc[0] + ONE_Q16) * SIZE_X;
      v1_sy <= (ndc[1] + ONE_Q16) * SIZE_Y;
      v1_sz <= ndc[2] + ONE_Q16;
    end
  end

  always_comb begin
    sat_x = half_sat(v1_sx);
    sat_y = half_sat(v1_sy);
    sat_z = half_sat(SCALED_W'(v1_sz));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (v1_wz) begin
        screen.screen_x <= '0;
        screen.screen_y <= '0;
        screen.depth    <= '0;
        screen.w_zero   <= 1'b1;
        screen.overflow <= 1'b0;
      end else begin
        screen.screen_x <= sat_x[COORD_W-1:0];
        screen.screen_y <= sat_y[COORD_W-1:0];
        screen.depth    <= sat_z[COORD_W-1:0];
        screen.w_zero   <= 1'b0;
        screen.overflow <= sat_x[COORD_W] | sat_y[COORD_W] | sat_z[COORD_W];
      end
    end
  end

endmodule

FILE: hw/rtl/vertex_project_to_screen.sv
// Channel   Direction  Fields                                       Handshake
// points    in         point_x, point_y, point_z                    valid / ready
// screen    out        screen_x, screen_y, depth, w_zero, overflow  valid / ready
// cfg       in         cfg_index, cfg_data                          cfg_we, no wait
//
// One point is accepted per cycle and one result leaves per cycle when the sink keeps up.
// The path runs through two matrix stages, the queue, one operand stage,
// 41 quotient stages (one bit per stage in each of the three dividers) and two viewport stages.
// Reset is synchronous and clears all valid state and loads the matrix with MAT_RESET.
// A stalled output freezes the back pipeline; the front keeps filling the four-entry
// queue and only drops points.ready once the queue is full and its last stage holds a point.
module vertex_project_to_screen #(
  parameter int VIEW_WIDTH  = 1920,
  parameter int VIEW_HEIGHT = 1080
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vpts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vpts_pkg::MAT_W-1:0]      cfg_data,
  vpts_in_if.sink                         points,
  vpts_out_if.source                      screen
);
  import vpts_pkg::*;

  // Front side: matrix registers, products and row sums.
  // A row sum is the clip coordinate in Q34.24.
  logic      push_valid;
  clip_t     push_data;
  logic      pop;
  clip_t     pop_data;
  q_status_t q_st;

  vpts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .points     (points),
    .q_st       (q_st),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // The queue lets the divider pipeline stall without backing up the matrix stages at once.
  vpts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_st      (q_st)
  );

  // Back side: perspective divide, viewport mapping and saturation.
  vpts_back #(
    .VIEW_WIDTH  (VIEW_WIDTH),
    .VIEW_HEIGHT (VIEW_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_st     (q_st),
    .pop      (pop),
    .pop_data (pop_data),
    .screen   (screen)
  );

  // A zero w result carries zero coordinates and no overflow.
  assert property (@(posedge clk) disable iff (rst)
    screen.valid && screen.w_zero |-> !screen.overflow && screen.screen_x == '0
      && screen.screen_y == '0 && screen.depth == '0)
    else $error("w_zero result with nonzero payload");

  // Input back-pressure only comes from a full queue.
  assert property (@(posedge clk) disable iff (rst)
    !points.ready |-> q_st.full)
    else $error("points stalled while queue has room");

  // The queue is never popped when empty nor pushed when full.
  assert property (@(posedge clk) disable iff (rst)
    !(pop && q_st.empty) && !(push_valid && q_st.full))
    else $error("queue underflow or overflow");

  // Nothing leaves right after reset.
  assert property (@(posedge clk)
    $past(rst) |-> !screen.valid)
    else $error("output valid right after reset");

endmodule

FILE: tb/sv/vertex_project_to_screen_tb.sv
`timescale 1ns / 100ps

module vertex_project_to_screen_tb;
  import vpts_pkg::*;

  // Screen size used by both the block and the predictor.
  localparam int VIEW_WIDTH  = 1920;
  localparam int VIEW_HEIGHT = 1080;

  // Idle time that drain adds once every expected result is back, so that the pipe empties.
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int LONG_HOLD    = 400;

  localparam longint ONE_FIX   = 64'sd65536;
  localparam longint NDC_LIMIT = 64'sd1 <<< 40;
  localparam longint INT_LIMIT = 64'sd1 <<< 24;

  // Register indexes, in the order of the matrix rows.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_M00_M01, REG_M02_M03, REG_M10_M11, REG_M12_M13,
    REG_M20_M21, REG_M22_M23, REG_M30_M31, REG_M32_M33
  } mat_reg_e;

  typedef struct {
    coord_t screen_x;
    coord_t screen_y;
    coord_t depth;
    logic   w_zero;
    logic   overflow;
  } screen_pt_t;

  // The scoreboard holds a copy of the matrix, predicts each projected point
  // when its input transaction is accepted, and compares results in order.
  class projection_board;
    logic [MAT_W-1:0] matrix [NUM_REGS];
    screen_pt_t       pending_pts [$];
    int               errors;
    int               checked;
    int               wz_seen;
    int               ovf_seen;

    function void reset_matrix();
      for (int i = 0; i < NUM_REGS; i++) matrix[i] = MAT_RESET[i];
    endfunction

    function void write_reg(int idx, logic [MAT_W-1:0] val);
      matrix[idx] = val;
    endfunction

    function longint entry(int row, int col);
      logic [MAT_W-1:0] r;
      r = matrix[row * 2 + col / 2];
      return (col % 2) ? longint'(coord_t'(r[63:32])) : longint'(coord_t'(r[31:0]));
    endfunction

    // Sum of the four truncated Q32.24 terms of one matrix row.
    function longint clip_row(int row, longint p [4]);
      longint acc;
      acc = 0;
      for (int c = 0; c < 4; c++) acc += (entry(row, c) * p[c]) / 256;
      return acc;
    endfunction

    // Sign-magnitude restoring divide giving Q24.16, clamped when the
    // integer part of the quotient reaches 2^24.
    function longint ndc_divide(longint num, longint den);
      bit neg;
      longint unsigned n, d, ip, rem, frac;
      longint q;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      ip = n / d;
      rem = n % d;
      frac = 0;
      if (ip >= INT_LIMIT) return neg ? -NDC_LIMIT : NDC_LIMIT;
      for (int i = 0; i < 16; i++) begin
        rem = rem << 1;
        frac = frac << 1;
        if (rem >= d) begin
          rem = rem - d;
          frac = frac | 1;
        end
      end
      q = longint'((ip << 16) | frac);
      return neg ? -q : q;
    endfunction

    function coord_t saturate(longint v, ref logic ovf);
      if (v > 64'sd2147483647) begin
        ovf = 1'b1;
        return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
        ovf = 1'b1;
        return 32'sh8000_0000;
      end
      return coord_t'(v);
    endfunction

    function void note_point(coord_t x, coord_t y, coord_t z);
      longint p [4];
      longint cx, cy, cz, cw, nx, ny, nz;
      screen_pt_t e;
      p[0] = x;
      p[1] = y;
      p[2] = z;
      p[3] = ONE_FIX;
      cx = clip_row(0, p);
      cy = clip_row(1, p);
      cz = clip_row(2, p);
      cw = clip_row(3, p);
      e.overflow = 1'b0;
      if (cw == 0) begin
        e.screen_x = '0;
        e.screen_y = '0;
        e.depth = '0;
        e.w_zero = 1'b1;
      end else begin
        nx = ndc_divide(cx, cw);
        ny = ndc_divide(cy, cw);
        nz = ndc_divide(cz, cw);
        e.w_zero = 1'b0;
        e.screen_x = saturate(((nx + ONE_FIX) * VIEW_WIDTH) / 2, e.overflow);
        e.screen_y = saturate(((ny + ONE_FIX) * VIEW_HEIGHT) / 2, e.overflow);
        e.depth = saturate((nz + ONE_FIX) / 2, e.overflow);
      end
      pending_pts.push_back(e);
    endfunction

    function void check_point(screen_pt_t got);
      screen_pt_t e;
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h d=%h", $time,
                 got.screen_x, got.screen_y, got.depth);
        errors++;
        return;
      end
      e = pending_pts.pop_front();
      checked++;
      if (got.w_zero) wz_seen++;
      if (got.overflow) ovf_seen++;
      if (got.screen_x !== e.screen_x) begin
        $display("%0t: screen_x expected %h actual %h", $time, e.screen_x, got.screen_x);
        errors++;
      end
      if (got.screen_y !== e.screen_y) begin
        $display("%0t: screen_y expected %h actual %h", $time, e.screen_y, got.screen_y);
        errors++;
      end
      if (got.depth !== e.depth) begin
        $display("%0t: depth expected %h actual %h", $time, e.depth, got.depth);
        errors++;
      end
      if (got.w_zero !== e.w_zero) begin
        $display("%0t: w_zero expected %b actual %b", $time, e.w_zero, got.w_zero);
        errors++;
      end
      if (got.overflow !== e.overflow) begin
        $display("%0t: overflow expected %b actual %b", $time, e.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MAT_W-1:0] cfg_data;

  vpts_in_if  pts ();
  vpts_out_if scr ();

  vertex_project_to_screen #(
    .VIEW_WIDTH (VIEW_WIDTH),
    .VIEW_HEIGHT(VIEW_HEIGHT)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .points   (pts),
    .screen   (scr)
  );

  projection_board board;
  int  cycle_count;
  bit  hold_request;
  int  points_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Global watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver side. Ready changes only at the falling edge. The pattern cycles
  // through several modes so that stalls land on every stage of the pipe, and a
  // long hold-off can be requested to fill the internal queue and push back on
  // the sender.
  initial begin
    int mode_left;
    int mode;
    int hold_left;
    scr.ready = 1'b0;
    mode_left = 0;
    mode = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        scr.ready <= 1'b0;
      end else begin
        case (mode)
          0: scr.ready <= 1'b1;
          1: scr.ready <= ($urandom_range(0, 99) < 70);
          2: scr.ready <= (cycle_count % 4 != 0);
          default: scr.ready <= ($urandom_range(0, 99) < 25);
        endcase
      end
    end
  end

  // Output monitor: a transaction completes at a rising edge with valid and ready high.
  always @(posedge clk) begin
    screen_pt_t got;
    if (!rst && scr.valid && scr.ready) begin
      got.screen_x = scr.screen_x;
      got.screen_y = scr.screen_y;
      got.depth = scr.depth;
      got.w_zero = scr.w_zero;
      got.overflow = scr.overflow;
      board.check_point(got);
    end
  end

  // Offers one point and waits until the block takes it. Valid is left high so
  // that a following point in the same burst goes out with no bubble.
  task automatic send_point(coord_t x, coord_t y, coord_t z);
    @(negedge clk);
    pts.valid <= 1'b1;
    pts.point_x <= x;
    pts.point_y <= y;
    pts.point_z <= z;
    do @(posedge clk); while (!pts.ready);
    board.note_point(x, y, z);
    points_sent++;
  endtask

  task automatic pause_input(int cycles);
    @(negedge clk);
    pts.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Waits until every predicted point has come back, then lets the pipe empty.
  task automatic drain();
    pause_input(1);
    while (board.pending_pts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all eight matrix registers back to back while the block is idle.
  task automatic load_matrix(logic [MAT_W-1:0] vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= mat_reg_e'(i);
      cfg_data <= vals[i];
      board.write_reg(i, vals[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic coord_t rand_coord(int style);
    case (style)
      0: return coord_t'($urandom);
      1: begin
        if ($urandom_range(0, 4) == 0) return '0;
        return coord_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0001_0000;
          3: return -32'sh0001_0000;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // Small entries keep the projection in range; full-range ones exercise saturation.
  function automatic logic [MAT_W-1:0] rand_pair(int style);
    coord_t lo, hi;
    lo = rand_coord(style);
    hi = rand_coord(style);
    return {hi, lo};
  endfunction

  task automatic random_phase(int count, int mat_style, int pt_style);
    logic [MAT_W-1:0] vals [NUM_REGS];
    int burst;
    int left;
    for (int i = 0; i < NUM_REGS; i++) vals[i] = rand_pair(mat_style);
    // Keep w meaningful most of the time: a modest constant term in row 3.
    if (mat_style == 1) vals[REG_M32_M33][63:32] = $urandom_range(1, 5) << 15;
    load_matrix(vals);
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      for (int b = 0; b < burst && left > 0; b++) begin
        send_point(rand_coord(pt_style == 3 ? $urandom_range(0, 2) : pt_style),
                   rand_coord(pt_style == 3 ? $urandom_range(0, 2) : pt_style),
                   rand_coord(pt_style == 3 ? $urandom_range(0, 2) : pt_style));
        left--;
      end
      if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 8));
    end
    drain();
  endtask

  initial begin
    logic [MAT_W-1:0] vals [NUM_REGS];
    board = new();
    board.reset_matrix();
    cycle_count = 0;
    hold_request = 1'b0;
    points_sent = 0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pts.valid = 1'b0;
    pts.point_x = '0;
    pts.point_y = '0;
    pts.point_z = '0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset matrix (MAT_RESET): extremes of every coordinate and a few plain points.
    send_point(32'sh0, 32'sh0, 32'sh0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000);
    send_point(-32'sh0000_8000, 32'sh0000_4000, -32'sh0001_0000);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0);
    send_point(32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0000_0001);
    send_point(32'sh0100_0000, -32'sh0100_0000, 32'sh00FF_FFFF);
    drain();

    // Row 3 all zero: every point has w of zero.
    for (int i = 0; i < NUM_REGS; i++) vals[i] = MAT_RESET[i];
    vals[REG_M30_M31] = '0;
    vals[REG_M32_M33] = '0;
    load_matrix(vals);
    send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    drain();

    // Perspective-like matrix: w follows z, so a zero z gives a zero w and
    // tiny z values give large quotients.
    vals[REG_M32_M33] = 64'h0000_0000_0001_0000;
    load_matrix(vals);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0001);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, -32'sh0000_0100);
    send_point(32'sh0000_8000, -32'sh0000_8000, 32'sh0002_0000);
    drain();

    // Extreme matrix entries: largest positive and most negative values.
    for (int i = 0; i < NUM_REGS; i++)
      vals[i] = (i % 2) ? 64'h8000_0000_8000_0000 : 64'h7FFF_FFFF_7FFF_FFFF;
    load_matrix(vals);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_point(32'sh0, 32'sh0, 32'sh0);
    drain();

    // All bits set, then all clear.
    for (int i = 0; i < NUM_REGS; i++) vals[i] = '1;
    load_matrix(vals);
    send_point(32'sh0001_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_point(32'sh0, 32'sh0, 32'sh0);
    drain();
    for (int i = 0; i < NUM_REGS; i++) vals[i] = '0;
    load_matrix(vals);
    send_point(32'sh1234_5678, 32'sh8765_4321, 32'sh0);
    drain();

    // The first random phase starts behind a long receiver hold-off so that
    // the queue fills and the block drops its input ready.
    hold_request = 1'b1;
    random_phase(250, 1, 1);
    random_phase(250, 1, 3);
    random_phase(200, 0, 0);
    random_phase(250, 2, 3);
    random_phase(250, 1, 2);
    random_phase(250, 3, 3);
    random_phase(250, 1, 1);

    $display("Covered %0d points over identity, zero-w, perspective, extreme and random matrices.",
             points_sent);
    $display("Checked %0d results: %0d with w zero, %0d saturated.",
             board.checked, board.wz_seen, board.ovf_seen);
    if (board.errors == 0 && board.pending_pts.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
